// ----- rtl/gasu_pkg.sv -----
// shared types and codes of the generic address access splitter
// request codes, status codes, decode and result records; no dependencies
package gasu_pkg;

	// request type codes
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_RESP  = 2'd2;

	// address space codes
	localparam logic [7:0] SPACE_MEM = 8'd0;
	localparam logic [7:0] SPACE_IO  = 8'd1;

	// largest size code that is supported
	localparam logic [7:0] SIZE_MAX = 8'd4;

	// widest field span in bits
	localparam int unsigned SPAN_MAX = 64;

	// completion status
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_FOUND   = 2'd1,
		ST_UNSUPPORTED = 2'd2,
		ST_BUS_ERROR   = 2'd3
	} status_t;

	// outcome of request decode
	typedef enum logic [1:0] {
		DEC_FAIL  = 2'd0,
		DEC_EMPTY = 2'd1,
		DEC_START = 2'd2
	} dec_kind_t;

	// decoded request, handed from the decoder to the sequencer
	typedef struct packed {
		dec_kind_t  kind;
		status_t    status;
		logic       is_io;
		logic [1:0] beat_log;   // beat width is 8 << beat_log bits
		logic [3:0] start_idx;
		logic [6:0] bits_left;
	} dec_t;

	// one result transaction
	typedef struct packed {
		logic        kind;
		logic        write;
		logic        io;
		logic [63:0] address;
		logic [3:0]  bytes;
		logic [63:0] data;
		status_t     status;
		logic [63:0] value;
	} res_t;

endpackage

// ----- rtl/gasu_decode.sv -----
// request decoder: validation and access width selection
// depends on gasu_pkg
module gasu_decode
	import gasu_pkg::*;
(
	input  logic [7:0]  addr_space,
	input  logic [63:0] reg_address,
	input  logic [7:0]  bit_width,
	input  logic [7:0]  field_offset,
	input  logic [7:0]  size_code,
	output dec_t        dec
);

	logic [8:0] sum;
	logic [8:0] span_m1;
	logic       natural;
	logic       zero_w;
	logic [3:0] e_raw;
	logic [3:0] e_len;
	logic [3:0] e_al;
	logic [3:0] e_cap;
	logic [2:0] tz;
	logic       is_io;
	logic [7:0] start_full;
	logic [8:0] start_bits;
	logic [8:0] left_full;

	assign sum     = {1'b0, field_offset} + {1'b0, bit_width};
	assign span_m1 = sum - 9'd1;
	assign is_io   = (addr_space == SPACE_IO);

	// natural width: no offset, width a power of two and whole bytes
	assign natural = (field_offset == 8'd0) && ((bit_width & (bit_width - 8'd1)) == 8'd0)
		&& (bit_width[2:0] == 3'd0);
	assign zero_w = natural && (bit_width == 8'd0);

	// bit length of the span minus one
	always_comb begin
		e_len = 4'd0;
		for (int i = 0; i < 9; i++) begin
			if (span_m1[i]) e_len = 4'(i + 1);
		end
	end

	// alignment limit from the low address bits
	always_comb begin
		tz = 3'd6;
		for (int i = 5; i >= 0; i--) begin
			if (reg_address[i]) tz = 3'(i);
		end
		e_al = 4'(tz) + 4'd3;
	end

	// width exponent before the space cap
	always_comb begin
		if (natural) begin
			priority if (bit_width[7]) e_raw = 4'd7;
			else if (bit_width[6]) e_raw = 4'd6;
			else if (bit_width[5]) e_raw = 4'd5;
			else if (bit_width[4]) e_raw = 4'd4;
			else e_raw = 4'd3;
		end else if (size_code != 8'd0) begin
			e_raw = size_code[3:0] + 4'd2;
		end else if (e_len <= 4'd3) begin
			e_raw = 4'd3;
		end else begin
			e_raw = (e_len < e_al) ? e_len : e_al;
		end
	end

	// cap at 32 bits for i/o and 64 for memory
	always_comb begin
		if (is_io) e_cap = (e_raw > 4'd5) ? 4'd5 : e_raw;
		else e_cap = (e_raw > 4'd6) ? 4'd6 : e_raw;
	end

	assign start_full = field_offset >> e_cap;
	assign start_bits = {1'b0, start_full} << e_cap;
	assign left_full  = sum - start_bits;

	// validation in order of precedence
	always_comb begin
		dec.is_io     = is_io;
		dec.beat_log  = 2'(e_cap - 4'd3);
		dec.start_idx = start_full[3:0];
		dec.bits_left = left_full[6:0];
		dec.kind      = DEC_FAIL;
		dec.status    = ST_OK;
		priority if (reg_address == 64'd0) begin
			dec.status = ST_NOT_FOUND;
		end else if ((addr_space != SPACE_MEM && addr_space != SPACE_IO)
			|| size_code > SIZE_MAX) begin
			dec.status = ST_UNSUPPORTED;
		end else if (!zero_w && sum > 9'(SPAN_MAX)) begin
			dec.status = ST_UNSUPPORTED;
		end else if (zero_w || sum == 9'd0 || start_bits >= sum) begin
			dec.kind = DEC_EMPTY;
		end else begin
			dec.kind = DEC_START;
		end
	end

endmodule

// ----- rtl/generic_address_access_splitter_unit.sv -----
// top level of the generic address access splitter
// depends on gasu_pkg and gasu_decode
//
// Accepts read and write requests for a register field and bus responses on one
// input channel and answers each with at most one result: a bus access command or
// a request completion. One transaction is taken every cycle while results drain;
// a transaction passes an input register, then the decode and beat logic, then
// the result register. Input is held only while a result waits and is not taken.
// Overall throughput of a request is set by the bus round trip: each beat needs
// one bus response.
module generic_address_access_splitter_unit
	import gasu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  addr_space,
	input  logic [63:0] reg_address,
	input  logic [7:0]  bit_width,
	input  logic [7:0]  field_offset,
	input  logic [7:0]  size_code,
	input  logic [63:0] write_value,
	input  logic [63:0] bus_data,
	input  logic        bus_error,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        result_kind,
	output logic        cmd_write,
	output logic        cmd_io,
	output logic [63:0] cmd_address,
	output logic [3:0]  cmd_bytes,
	output logic [63:0] cmd_data,
	output logic [1:0]  status,
	output logic [63:0] read_value
);

	// input register
	logic        v_s1;
	logic [1:0]  type_s1;
	logic [7:0]  space_s1;
	logic [63:0] addr_s1;
	logic [7:0]  width_s1;
	logic [7:0]  offset_s1;
	logic [7:0]  size_s1;
	logic [63:0] wval_s1;
	logic [63:0] bdata_s1;
	logic        berr_s1;

	// result register
	logic        v_s2;
	res_t        res_s2;

	// request state
	logic        busy_q;
	logic        wr_q;
	logic        io_q;
	logic [63:0] base_q;
	logic [1:0]  lb_q;
	logic [3:0]  idx_q;
	logic [6:0]  left_q;
	logic [63:0] gath_q;
	logic [63:0] pwr_q;

	// next values
	logic        busy_d;
	logic        wr_d;
	logic        io_d;
	logic [63:0] base_d;
	logic [1:0]  lb_d;
	logic [3:0]  idx_d;
	logic [6:0]  left_d;
	logic [63:0] gath_d;
	logic [63:0] pwr_d;
	logic        has_res;
	res_t        res_d;

	logic        adv;
	logic        load;
	dec_t        dec;
	logic [9:0]  cur_shift;
	logic [63:0] cur_mask;
	logic [6:0]  cur_bits;
	logic [6:0]  take;

	function automatic logic [9:0] beat_shift(logic [3:0] idx, logic [1:0] lb);
		return {6'd0, idx} << (3'(lb) + 3'd3);
	endfunction

	function automatic logic [63:0] beat_mask(logic [1:0] lb);
		return (lb == 2'd3) ? {64{1'b1}} : ~({64{1'b1}} << (7'd8 << lb));
	endfunction

	function automatic res_t make_cmd(logic wr, logic io, logic [63:0] base, logic [1:0] lb,
		logic [3:0] idx, logic [63:0] pwr);
		logic [9:0] sh;
		res_t       r;
		sh        = beat_shift(idx, lb);
		r         = '0;
		r.kind    = 1'b0;
		r.write   = wr;
		r.io      = io;
		r.address = base + {57'd0, sh[9:3]};
		r.bytes   = 4'd1 << lb;
		r.data    = (wr && sh < 10'd64) ? ((pwr >> sh[5:0]) & beat_mask(lb)) : 64'd0;
		r.status  = ST_OK;
		return r;
	endfunction

	function automatic res_t make_done(status_t st, logic [63:0] value);
		res_t r;
		r        = '0;
		r.kind   = 1'b1;
		r.status = st;
		r.value  = value;
		return r;
	endfunction

	// handshake
	assign adv       = v_s1 && (!v_s2 || res_ready);
	assign req_ready = !v_s1 || adv;
	assign load      = req_valid && req_ready;

	gasu_decode u_decode (
		.addr_space   (space_s1),
		.reg_address  (addr_s1),
		.bit_width    (width_s1),
		.field_offset (offset_s1),
		.size_code    (size_s1),
		.dec          (dec)
	);

	// current beat geometry
	assign cur_shift = beat_shift(idx_q, lb_q);
	assign cur_mask  = beat_mask(lb_q);
	assign cur_bits  = 7'd8 << lb_q;
	assign take      = (left_q < cur_bits) ? left_q : cur_bits;

	// per transaction processing
	always_comb begin
		busy_d  = busy_q;
		wr_d    = wr_q;
		io_d    = io_q;
		base_d  = base_q;
		lb_d    = lb_q;
		idx_d   = idx_q;
		left_d  = left_q;
		gath_d  = gath_q;
		pwr_d   = pwr_q;
		has_res = 1'b0;
		res_d   = '0;
		unique case (type_s1)
			REQ_READ, REQ_WRITE: begin
				if (!busy_q) begin
					has_res = 1'b1;
					unique case (dec.kind)
						DEC_FAIL:  res_d = make_done(dec.status, 64'd0);
						DEC_EMPTY: res_d = make_done(ST_OK, 64'd0);
						DEC_START: begin
							busy_d = 1'b1;
							wr_d   = (type_s1 == REQ_WRITE);
							io_d   = dec.is_io;
							base_d = addr_s1;
							lb_d   = dec.beat_log;
							idx_d  = dec.start_idx;
							left_d = dec.bits_left;
							gath_d = 64'd0;
							pwr_d  = (type_s1 == REQ_WRITE) ? wval_s1 : 64'd0;
							res_d  = make_cmd(wr_d, io_d, base_d, lb_d, idx_d, pwr_d);
						end
						default: has_res = 1'b0;
					endcase
				end
			end
			REQ_RESP: begin
				if (busy_q) begin
					has_res = 1'b1;
					if (berr_s1) begin
						busy_d = 1'b0;
						res_d  = make_done(ST_BUS_ERROR, 64'd0);
					end else begin
						if (!wr_q && cur_shift < 10'd64)
							gath_d = gath_q | ((bdata_s1 & cur_mask) << cur_shift[5:0]);
						left_d = left_q - take;
						idx_d  = idx_q + 4'd1;
						if (left_d == 7'd0) begin
							busy_d = 1'b0;
							res_d  = make_done(ST_OK, wr_q ? 64'd0 : gath_d);
						end else begin
							res_d = make_cmd(wr_q, io_q, base_q, lb_q, idx_d, pwr_q);
						end
					end
				end
			end
			default: has_res = 1'b0;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			type_s1   <= req_type;
			space_s1  <= addr_space;
			addr_s1   <= reg_address;
			width_s1  <= bit_width;
			offset_s1 <= field_offset;
			size_s1   <= size_code;
			wval_s1   <= write_value;
			bdata_s1  <= bus_data;
			berr_s1   <= bus_error;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv && has_res) begin
			v_s2 <= 1'b1;
		end else if (res_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			res_s2 <= res_d;
		end
	end

	// request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wr_q   <= 1'b0;
			io_q   <= 1'b0;
			base_q <= 64'd0;
			lb_q   <= 2'd0;
			idx_q  <= 4'd0;
			left_q <= 7'd0;
			gath_q <= 64'd0;
			pwr_q  <= 64'd0;
		end else if (adv) begin
			busy_q <= busy_d;
			wr_q   <= wr_d;
			io_q   <= io_d;
			base_q <= base_d;
			lb_q   <= lb_d;
			idx_q  <= idx_d;
			left_q <= left_d;
			gath_q <= gath_d;
			pwr_q  <= pwr_d;
		end
	end

	// output ports
	assign res_valid   = v_s2;
	assign result_kind = res_s2.kind;
	assign cmd_write   = res_s2.write;
	assign cmd_io      = res_s2.io;
	assign cmd_address = res_s2.address;
	assign cmd_bytes   = res_s2.bytes;
	assign cmd_data    = res_s2.data;
	assign status      = res_s2.status;
	assign read_value  = res_s2.value;

endmodule

// ----- tb/sv/access_split_checker.sv -----
// result checker for the generic address access splitter testbench
// predicts every result from the accepted transactions and compares; uses gasu_pkg
`timescale 1ns / 100ps

module access_split_checker
	import gasu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  addr_space,
	input  logic [63:0] reg_address,
	input  logic [7:0]  bit_width,
	input  logic [7:0]  field_offset,
	input  logic [7:0]  size_code,
	input  logic [63:0] write_value,
	input  logic [63:0] bus_data,
	input  logic        bus_error,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic        result_kind,
	input  logic        cmd_write,
	input  logic        cmd_io,
	input  logic [63:0] cmd_address,
	input  logic [3:0]  cmd_bytes,
	input  logic [63:0] cmd_data,
	input  logic [1:0]  status,
	input  logic [63:0] read_value,
	output int          failures,
	output int          owed
);

	localparam int REPORT_CAP = 100;

	// shadow copy of the splitter state
	logic        op_busy;
	logic        op_write;
	logic        op_io;
	logic [63:0] op_base;
	int unsigned op_beat_bits;
	int unsigned op_beat_idx;
	int unsigned op_bits_left;
	logic [63:0] op_gathered;
	logic [63:0] op_wdata;

	// results predicted but not yet seen on the result channel
	res_t results_owed[$];

	// all ones over the width of one beat
	function automatic logic [63:0] lane_mask(input int unsigned bits);
		if (bits >= 64)
			return '1;
		return ~({64{1'b1}} << bits);
	endfunction

	// completion transaction; the kind bit flags a completion
	function automatic res_t completion(input status_t st, input logic [63:0] value);
		res_t r;
		r        = '0;
		r.kind   = 1'b1;
		r.status = st;
		r.value  = value;
		return r;
	endfunction

	// bus command for the current beat
	function automatic res_t beat_command();
		res_t        r;
		int unsigned shift;
		r         = '0;
		shift     = op_beat_idx * op_beat_bits;
		r.write   = op_write;
		r.io      = op_io;
		r.address = op_base + 64'(op_beat_idx) * 64'(op_beat_bits / 8);
		r.bytes   = 4'(op_beat_bits / 8);
		r.status  = ST_OK;
		if (op_write && shift < 64)
			r.data = (op_wdata >> shift) & lane_mask(op_beat_bits);
		return r;
	endfunction

	// beat width: natural width, else size code, else aligned power of two, then capped
	function automatic int unsigned beat_width(input logic [7:0] space, input logic [63:0] addr,
		input int unsigned width, input int unsigned offset, input int unsigned size);
		int unsigned b;
		int unsigned span;
		int unsigned len;
		if (offset == 0 && (width & (width - 1)) == 0 && (width % 8) == 0) begin
			b = width;
		end else if (size != 0) begin
			b = 8 << (size - 1);
		end else begin
			span = offset + width - 1;
			len  = 0;
			while (span != 0) begin
				len  = len + 1;
				span = span >> 1;
			end
			b = 1 << len;
			if (b <= 8) begin
				b = 8;
			end else begin
				while ((addr & 64'(b / 8 - 1)) != 0)
					b = b / 2;
			end
		end
		if (space == SPACE_IO)
			return (b < 32) ? b : 32;
		return (b < 64) ? b : 64;
	endfunction

	// advance the shadow state by one transaction; returns 1 when it causes a result
	function automatic bit step_splitter(input logic [1:0] op, input logic [7:0] space,
		input logic [63:0] addr, input logic [7:0] width, input logic [7:0] offset,
		input logic [7:0] size, input logic [63:0] wval, input logic [63:0] bdata,
		input logic berr, output res_t r);
		int unsigned sum;
		int unsigned b;
		int unsigned span_bits;
		int unsigned first;
		int unsigned shift;
		r = '0;
		if (op == REQ_READ || op == REQ_WRITE) begin
			if (op_busy)
				return 1'b0;
			sum = int'(offset) + int'(width);
			if (addr == '0) begin
				r = completion(ST_NOT_FOUND, '0);
				return 1'b1;
			end
			if ((space != SPACE_MEM && space != SPACE_IO) || size > SIZE_MAX) begin
				r = completion(ST_UNSUPPORTED, '0);
				return 1'b1;
			end
			b         = beat_width(space, addr, width, offset, size);
			span_bits = (b == 0) ? 0 : ((sum + b - 1) / b) * b;
			if (span_bits > SPAN_MAX) begin
				r = completion(ST_UNSUPPORTED, '0);
				return 1'b1;
			end
			// nothing to move: empty field or every beat below the offset
			if (sum == 0 || b == 0) begin
				r = completion(ST_OK, '0);
				return 1'b1;
			end
			first = offset / b;
			if (first * b >= sum) begin
				r = completion(ST_OK, '0);
				return 1'b1;
			end
			op_busy      = 1'b1;
			op_write     = (op == REQ_WRITE);
			op_io        = (space == SPACE_IO);
			op_base      = addr;
			op_beat_bits = b;
			op_beat_idx  = first;
			op_bits_left = sum - first * b;
			op_gathered  = '0;
			op_wdata     = (op == REQ_WRITE) ? wval : '0;
			r = beat_command();
			return 1'b1;
		end
		if (op != REQ_RESP || !op_busy)
			return 1'b0;
		// bus error aborts the whole request
		if (berr) begin
			op_busy = 1'b0;
			r = completion(ST_BUS_ERROR, '0);
			return 1'b1;
		end
		shift = op_beat_idx * op_beat_bits;
		if (!op_write && shift < 64)
			op_gathered = op_gathered | ((bdata & lane_mask(op_beat_bits)) << shift);
		op_bits_left = op_bits_left - ((op_bits_left < op_beat_bits) ? op_bits_left : op_beat_bits);
		op_beat_idx  = (op_beat_idx + 1) & 15;
		if (op_bits_left == 0) begin
			op_busy = 1'b0;
			r = completion(ST_OK, op_write ? '0 : op_gathered);
			return 1'b1;
		end
		r = beat_command();
		return 1'b1;
	endfunction

	// count a mismatch, print only the first ones
	task automatic compare(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			if (failures < REPORT_CAP)
				$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			failures++;
			if (failures == REPORT_CAP)
				$display("%0t ns: further mismatches are counted, not printed", $time);
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t fresh;
		if (!arst_n) begin
			op_busy      = 1'b0;
			op_write     = 1'b0;
			op_io        = 1'b0;
			op_base      = '0;
			op_beat_bits = 0;
			op_beat_idx  = 0;
			op_bits_left = 0;
			op_gathered  = '0;
			op_wdata     = '0;
			failures     = 0;
			results_owed.delete();
			owed <= 0;
		end else begin
			// result side: oldest expectation first
			if (res_valid && res_ready) begin
				if (results_owed.size() == 0) begin
					if (failures < REPORT_CAP)
						$display("%0t ns: unexpected result, expected nothing, actual kind %0h status %0h",
							$time, result_kind, status);
					failures++;
				end else begin
					want = results_owed.pop_front();
					compare("result_kind", want.kind, result_kind);
					compare("cmd_write", want.write, cmd_write);
					compare("cmd_io", want.io, cmd_io);
					compare("cmd_address", want.address, cmd_address);
					compare("cmd_bytes", want.bytes, cmd_bytes);
					compare("cmd_data", want.data, cmd_data);
					compare("status", want.status, status);
					compare("read_value", want.value, read_value);
				end
			end
			// request side: predict what this transaction causes
			if (req_valid && req_ready) begin
				if (step_splitter(req_type, addr_space, reg_address, bit_width, field_offset,
					size_code, write_value, bus_data, bus_error, fresh))
					results_owed.push_back(fresh);
			end
			owed <= results_owed.size();
		end
	end

endmodule

// ----- tb/sv/generic_address_access_splitter_unit_tb.sv -----
// testbench top for the generic address access splitter
// drives requests and bus responses, verdict from access_split_checker; uses gasu_pkg
`timescale 1ns / 100ps

module generic_address_access_splitter_unit_tb;
	import gasu_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN       = 20;

	// request type the block never decodes
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        req_valid    = 1'b0;
	logic        req_ready;
	logic [1:0]  req_type     = REQ_READ;
	logic [7:0]  addr_space   = SPACE_MEM;
	logic [63:0] reg_address  = '0;
	logic [7:0]  bit_width    = '0;
	logic [7:0]  field_offset = '0;
	logic [7:0]  size_code    = '0;
	logic [63:0] write_value  = '0;
	logic [63:0] bus_data     = '0;
	logic        bus_error    = 1'b0;
	logic        res_valid;
	logic        res_ready    = 1'b0;
	logic        result_kind;
	logic        cmd_write;
	logic        cmd_io;
	logic [63:0] cmd_address;
	logic [3:0]  cmd_bytes;
	logic [63:0] cmd_data;
	logic [1:0]  status;
	logic [63:0] read_value;
	int          failures;
	int          owed;

	// pressure knobs, percent of cycles
	int tx_idle_pct = 35;
	int rx_idle_pct = 55;
	int noise_pct   = 0;

	// bookkeeping
	int          accesses    = 0;
	int          responses   = 0;
	int          bus_faults  = 0;
	int          strays      = 0;
	int          results_due = 0;
	int          res_seen    = 0;
	logic        last_done   = 1'b0;
	int unsigned cycles_run  = 0;

	generic_address_access_splitter_unit u_dut (.*);

	access_split_checker u_checker (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver stalls
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// track results for flow control
	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_seen  <= res_seen + 1;
			last_done <= result_kind;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
		if (cycles_run == CYCLE_LIMIT) begin
			$display("%0t ns: no progress within %0d cycles", $time, CYCLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// present one transaction and hold it until accepted
	task automatic offer(input logic [1:0] op, input logic [7:0] sp, input logic [63:0] addr,
		input logic [7:0] w, input logic [7:0] off, input logic [7:0] sz,
		input logic [63:0] wv, input logic [63:0] bd, input logic be);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		req_type     <= op;
		addr_space   <= sp;
		reg_address  <= addr;
		bit_width    <= w;
		field_offset <= off;
		size_code    <= sz;
		write_value  <= wv;
		bus_data     <= bd;
		bus_error    <= be;
		do @(posedge clk); while (!req_ready);
	endtask

	// transaction the block ignores in its current state
	task automatic stray(input logic [1:0] op);
		offer(op, 8'($urandom), rand64(), 8'($urandom), 8'($urandom), 8'($urandom),
			rand64(), rand64(), 1'($urandom));
		strays++;
	endtask

	// wait for the single result of the last meaningful transaction
	task automatic await_result(output logic done);
		results_due++;
		while (res_seen < results_due) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		done = last_done;
	endtask

	// one request, then one bus response per command until the completion
	task automatic run_access(input logic [1:0] op, input logic [7:0] sp,
		input logic [63:0] addr, input logic [7:0] w, input logic [7:0] off,
		input logic [7:0] sz, input logic [63:0] wv, input int err_pct);
		logic done;
		logic fault;
		offer(op, sp, addr, w, off, sz, wv, rand64(), 1'($urandom));
		accesses++;
		if ($urandom_range(99) < noise_pct)
			stray(REQ_UNUSED);
		await_result(done);
		while (!done) begin
			// block is waiting for the bus: requests are ignored now
			if ($urandom_range(99) < noise_pct)
				stray(($urandom_range(2) == 0) ? REQ_UNUSED :
					(($urandom_range(1) == 0) ? REQ_READ : REQ_WRITE));
			fault = ($urandom_range(99) < err_pct);
			offer(REQ_RESP, 8'($urandom), rand64(), 8'($urandom), 8'($urandom), 8'($urandom),
				rand64(), rand64(), fault);
			responses++;
			if (fault)
				bus_faults++;
			await_result(done);
		end
		// idle again: bus responses are ignored now
		if ($urandom_range(99) < noise_pct)
			stray(($urandom_range(1) == 0) ? REQ_RESP : REQ_UNUSED);
	endtask

	// mostly well-formed requests with random content, some malformed
	task automatic random_access();
		logic [63:0] addr;
		logic [7:0]  sp;
		logic [7:0]  w;
		logic [7:0]  off;
		logic [7:0]  sz;
		int          pick;
		pick = $urandom_range(99);
		addr = rand64();
		if ($urandom_range(15) == 0)
			addr = 64'hFFFF_FFFF_FFFF_FFC0 | 64'($urandom_range(63));
		if ($urandom_range(1) == 1)
			addr = addr & ({64{1'b1}} << $urandom_range(6));
		if (addr == '0)
			addr = 64'h1000;
		sp  = ($urandom_range(1) == 0) ? SPACE_MEM : SPACE_IO;
		sz  = 8'($urandom_range(4));
		w   = 8'($urandom_range(1, 64));
		off = 8'($urandom_range(0, 64 - w));
		if (pick < 4) begin
			addr = '0;
			sp   = 8'($urandom);
			sz   = 8'($urandom);
		end else if (pick < 8) begin
			sp = 8'($urandom_range(2, 255));
		end else if (pick < 11) begin
			sz = 8'($urandom_range(5, 255));
		end else if (pick < 16) begin
			w   = 8'($urandom);
			off = 8'($urandom);
		end else if (pick < 40) begin
			// natural widths, including zero and one too wide
			w   = ($urandom_range(5) == 0) ? 8'd0 : 8'(8 << $urandom_range(4));
			off = '0;
		end else if (pick < 44) begin
			// no bits at all, possibly past whole beats
			w   = '0;
			off = 8'($urandom_range(63));
		end
		run_access(($urandom_range(1) == 0) ? REQ_READ : REQ_WRITE, sp, addr, w, off, sz,
			rand64(), 4);
	endtask

	// stimulus and verdict
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: failures, empty fields, natural and capped widths, skipped beats
		run_access(REQ_READ, SPACE_MEM, 64'h0, 8'd32, 8'd0, 8'd3, rand64(), 0);
		run_access(REQ_WRITE, 8'd2, 64'h1000, 8'd32, 8'd0, 8'd3, rand64(), 0);
		run_access(REQ_READ, 8'hFF, 64'h2000, 8'hFF, 8'hFF, 8'hFF, rand64(), 0);
		run_access(REQ_READ, SPACE_IO, 64'h3000, 8'd16, 8'd0, 8'd5, rand64(), 0);
		run_access(REQ_READ, SPACE_MEM, 64'h4000, 8'hFF, 8'hFF, SIZE_MAX, rand64(), 0);
		run_access(REQ_READ, SPACE_MEM, 64'h5000, 8'd0, 8'd0, 8'd0, rand64(), 0);
		run_access(REQ_WRITE, SPACE_MEM, 64'h6000, 8'd0, 8'd16, 8'd2, rand64(), 0);
		run_access(REQ_READ, SPACE_MEM, 64'hFFFF_FFFF_FFFF_FFF8, 8'd64, 8'd0, 8'd0,
			rand64(), 0);
		run_access(REQ_WRITE, SPACE_MEM, 64'h7004, 8'd32, 8'd0, 8'd1,
			64'hFFFF_FFFF_FFFF_FFFF, 0);
		noise_pct = 100;
		run_access(REQ_WRITE, SPACE_IO, 64'hFFFF_FFFF_FFFF_FFFC, 8'd64, 8'd0, 8'd0,
			64'hA5A5_5A5A_0123_4567, 0);
		noise_pct = 0;
		run_access(REQ_READ, SPACE_MEM, 64'h8000, 8'd8, 8'd40, 8'd1, rand64(), 0);
		run_access(REQ_READ, SPACE_MEM, 64'h9001, 8'd10, 8'd3, 8'd0, rand64(), 0);
		run_access(REQ_READ, SPACE_MEM, 64'hA010, 8'd64, 8'd1, 8'd0, rand64(), 0);
		run_access(REQ_WRITE, SPACE_MEM, 64'hB000, 8'd12, 8'd0, 8'd1,
			64'h5555_AAAA_5555_AAAA, 100);
		stray(REQ_RESP);
		stray(REQ_UNUSED);

		// random: receiver lazy, then sender lazy, then full rate
		noise_pct = 12;
		while (accesses + responses < 570)
			random_access();
		tx_idle_pct = 55;
		rx_idle_pct = 35;
		while (accesses + responses < 1140)
			random_access();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (accesses + responses < 1710)
			random_access();

		// drain
		req_valid <= 1'b0;
		while (owed != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d requests, %0d bus responses (%0d with bus error), %0d ignored",
			accesses, responses, bus_faults, strays);
		$display("%0d results compared over three handshake pressure phases, %0d mismatches",
			res_seen, failures);
		if (failures == 0 && owed == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/gasu_pkg.sv
rtl/gasu_decode.sv
rtl/generic_address_access_splitter_unit.sv
tb/sv/access_split_checker.sv
tb/sv/generic_address_access_splitter_unit_tb.sv
